### rtl/mktd_pkg.sv
// ----------------------------------------------------------------------------
// Multi-keyword text detector package
// Keyword table, widths, the transaction token passed along the cell chain,
// and the per-keyword prefix automaton step.
// ----------------------------------------------------------------------------
package mktd_pkg;

    localparam int NUM_KEYWORDS    = 10;
    localparam int MAX_KEYWORD_LEN = 10;
    localparam int KW_SLOTS        = 10;
    localparam int KW_ROOM         = 16;
    localparam int CASE_OFFSET     = 32;

    localparam int MASK_W   = KW_SLOTS;
    localparam int POS_W    = 4;
    localparam int KW_IDX_W = $clog2(KW_SLOTS);

    localparam logic [7:0] NUL = 8'h00;

    localparam logic [7:0] KW_TABLE [KW_SLOTS][KW_ROOM] = '{
        '{"t","r","u","m","p",NUL,NUL,NUL,NUL,NUL,NUL,NUL,NUL,NUL,NUL,NUL},
        '{"h","i","l","l","a","r","y",NUL,NUL,NUL,NUL,NUL,NUL,NUL,NUL,NUL},
        '{"o","b","a","m","a",NUL,NUL,NUL,NUL,NUL,NUL,NUL,NUL,NUL,NUL,NUL},
        '{"p","o","l","i","t","i","c",NUL,NUL,NUL,NUL,NUL,NUL,NUL,NUL,NUL},
        '{"v","o","t","e",NUL,NUL,NUL,NUL,NUL,NUL,NUL,NUL,NUL,NUL,NUL,NUL},
        '{"e","l","e","c","t",NUL,NUL,NUL,NUL,NUL,NUL,NUL,NUL,NUL,NUL,NUL},
        '{"g","o","v","e","r","n",NUL,NUL,NUL,NUL,NUL,NUL,NUL,NUL,NUL,NUL},
        '{"p","r","e","s","i","d","e","n","t",NUL,NUL,NUL,NUL,NUL,NUL,NUL},
        '{"r","e","p","u","b","l","i","c","a","n",NUL,NUL,NUL,NUL,NUL,NUL},
        '{"d","e","m","o","c","r","a","t",NUL,NUL,NUL,NUL,NUL,NUL,NUL,NUL}
    };

    typedef struct packed {
        logic              valid;
        logic [7:0]        text_byte;
        logic              eot;
        logic [MASK_W-1:0] mask;
    } token_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             full;
    } step_t;

    function automatic int kw_length(input int k);
        int cap;
        int n;
        cap = (MAX_KEYWORD_LEN > KW_ROOM - 1) ? KW_ROOM - 1 : MAX_KEYWORD_LEN;
        n = 0;
        if (k < KW_SLOTS) begin
            for (int i = 0; i < KW_ROOM - 1; i++) begin
                if (n == i && n < cap && KW_TABLE[k][i] != NUL) begin
                    n = i + 1;
                end
            end
        end
        return n;
    endfunction

    function automatic logic byte_is(input logic [7:0] c, input logic [7:0] letter);
        return (c == letter) ||
               (int'(letter) >= CASE_OFFSET && int'(c) == int'(letter) - CASE_OFFSET);
    endfunction

    // kw[a .. a+n-1] equals kw[b .. b+n-1]
    function automatic logic same_run(input int k, input int a, input int b, input int n);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < KW_ROOM; i++) begin
            if (i < n) begin
                if (a + i >= KW_ROOM || b + i >= KW_ROOM) begin
                    ok = 1'b0;
                end else if (KW_TABLE[k][a + i] != KW_TABLE[k][b + i]) begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

    // One byte through keyword k's prefix automaton.
    function automatic step_t kw_step(input logic [KW_IDX_W-1:0] k,
                                      input logic [POS_W-1:0] p,
                                      input logic [7:0] c);
        step_t r;
        int    ki;
        int    len;
        int    pp;
        int    nxt;
        logic  done;
        ki   = int'(k);
        len  = kw_length(ki);
        pp   = (int'(p) >= len) ? 0 : int'(p);
        nxt  = 0;
        done = 1'b0;
        r.full = 1'b0;
        if (len != 0) begin
            for (int l = KW_ROOM - 1; l >= 1; l--) begin
                if (!done && l <= pp + 1) begin
                    if (byte_is(c, KW_TABLE[ki][l - 1]) &&
                        same_run(ki, 0, pp + 1 - l, l - 1)) begin
                        nxt  = l;
                        done = 1'b1;
                    end
                end
            end
            if (nxt == len) begin
                r.full = 1'b1;
                nxt    = 0;
                done   = 1'b0;
                // fall back to the longest border of the whole keyword
                for (int l = KW_ROOM - 2; l >= 1; l--) begin
                    if (!done && l <= len - 1 && same_run(ki, 0, len - l, l)) begin
                        nxt  = l;
                        done = 1'b1;
                    end
                end
            end
        end
        r.pos = POS_W'(nxt);
        return r;
    endfunction

endpackage

### rtl/mktd_cell.sv
// ----------------------------------------------------------------------------
// Keyword cell
// Tracks one keyword's match position and found flag; takes the byte token
// from its left neighbor, adds its hit bit and hands it to the right.
// ----------------------------------------------------------------------------
module mktd_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [mktd_pkg::KW_IDX_W-1:0] kw_idx,
    input  logic                          kw_enable,
    input  logic                          advance,
    input  mktd_pkg::token_t              tok_in,
    output mktd_pkg::token_t              tok_out
);

    logic [mktd_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                       found_reg, found_next;
    mktd_pkg::token_t           tok_reg, tok_next;
    mktd_pkg::step_t            step;
    logic                       found_now;
    logic                       hit;

    always_comb begin
        step       = mktd_pkg::kw_step(kw_idx, pos_reg, tok_in.text_byte);
        found_now  = found_reg | (step.full & kw_enable);
        hit        = found_now & kw_enable;
        pos_next   = pos_reg;
        found_next = found_reg;
        tok_next   = tok_reg;
        if (advance) begin
            tok_next      = tok_in;
            tok_next.mask = tok_in.mask | (mktd_pkg::MASK_W'(hit) << kw_idx);
            if (tok_in.valid) begin
                // end of text: clear after this byte's result is formed
                if (tok_in.eot) begin
                    pos_next   = '0;
                    found_next = 1'b0;
                end else begin
                    pos_next   = step.pos;
                    found_next = found_now;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            found_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            pos_reg   <= pos_next;
            found_reg <= found_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg == '0) || (int'(pos_reg) < mktd_pkg::kw_length(int'(kw_idx))))
        else $error("match position beyond keyword length");

    a_found_needs_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        (found_reg && !$past(found_reg)) |-> $past(kw_enable))
        else $error("found flag set for a disabled keyword");

    a_token_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(tok_reg))
        else $error("token moved while chain stalled");

endmodule

### rtl/multi_keyword_text_detector.sv
// ----------------------------------------------------------------------------
// Multi-keyword text detector
// Case-insensitive substring detection of ten fixed keywords over a byte
// stream, built as a chain of keyword cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one text byte per transaction, s_end_of_text on the last
//   byte of a text. m_* channel: one result per byte, in order: the mask of
//   enabled keywords found so far in the text, an any-hit flag and the
//   echoed end-of-text flag. cfg_* channel: writes keyword_enable
//   (one bit per keyword), always ready; write it while the block is idle.
//   Each byte passes through one register per keyword cell, in chain order,
//   from input to result; each cell updates its keyword as the byte passes by.
//   Throughput: one byte per cycle while the receiver does not stall.
//   When the receiver stalls the whole chain holds and s_ready drops; the
//   last cell's register is the output register.
//   Reset clears all match positions and found flags and enables all
//   keywords. After an end-of-text byte each cell clears its keyword state.
// ----------------------------------------------------------------------------
module multi_keyword_text_detector (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_text_byte,
    input  logic                        s_end_of_text,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [mktd_pkg::MASK_W-1:0] m_hit_mask,
    output logic                        m_any_hit,
    output logic                        m_text_done,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mktd_pkg::MASK_W-1:0] cfg_keyword_enable
);

    localparam int N = mktd_pkg::NUM_KEYWORDS;

    logic [mktd_pkg::MASK_W-1:0] keyword_enable_reg, keyword_enable_next;
    mktd_pkg::token_t            tok [N+1];
    logic                        advance;

    assign cfg_ready = 1'b1;

    always_comb begin
        keyword_enable_next = keyword_enable_reg;
        if (cfg_valid && cfg_ready) begin
            keyword_enable_next = cfg_keyword_enable;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keyword_enable_reg <= '1;
        end else begin
            keyword_enable_reg <= keyword_enable_next;
        end
    end

    assign advance = !tok[N].valid || m_ready;
    assign s_ready = advance;

    assign tok[0] = {s_valid, s_text_byte, s_end_of_text, mktd_pkg::MASK_W'(0)};

    for (genvar k = 0; k < N; k++) begin : g_cell
        mktd_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .kw_idx    (mktd_pkg::KW_IDX_W'(k)),
            .kw_enable (keyword_enable_reg[k]),
            .advance   (advance),
            .tok_in    (tok[k]),
            .tok_out   (tok[k+1])
        );
    end

    assign m_valid     = tok[N].valid;
    assign m_hit_mask  = tok[N].mask;
    assign m_any_hit   = |tok[N].mask;
    assign m_text_done = tok[N].eot;

    a_mask_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && $stable(keyword_enable_reg)) |->
            ((m_hit_mask & ~keyword_enable_reg) == '0))
        else $error("hit reported for a disabled keyword");

    a_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> tok[1].valid)
        else $error("accepted transaction did not enter the chain");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !tok[N-1].valid) |=> !m_valid)
        else $error("result repeated after it was taken");

endmodule
